>>> src/scts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere collision time search package
// Shared widths, codes and handshake structs of the collision time search core.
// ----------------------------------------------------------------------------
package scts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ID_BITS   = 32;
  localparam int IdW       = (ID_BITS < 32) ? ID_BITS : 32;

  localparam int XW    = 33;                  // position / velocity difference
  localparam int AccW  = 68 - FRAC_BITS;      // dot product accumulators, signed
  localparam int DrW   = 64;                  // x.x minus radius squared, signed
  localparam int SrW   = 41;                  // contact radius
  localparam int NW    = 35;                  // wall distance, signed
  localparam int QW    = 31;                  // quotient bits, times below 2^31
  localparam int WideW = 128;
  localparam int MulW  = 64;
  localparam int RemW  = 68;
  localparam int StepFacShift = 8;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } arith_op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_WALL = 2'd1,
    KIND_PART = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CFG_NEAR_MODE   = 3'd0,
    CFG_WALL_ENABLE = 3'd1,
    CFG_WALL_Z      = 3'd2,
    CFG_SUB_STEP    = 3'd3,
    CFG_STEP_FAC    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALL_MUL,
    ST_WALL_DIV,
    ST_DOT,
    ST_SR,
    ST_SQ,
    ST_R2,
    ST_PV,
    ST_SQRT,
    ST_RHS,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [WideW-1:0] a;
    logic [MulW-1:0]  b;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

endpackage

`default_nettype wire

>>> src/scts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere collision time search channels
// Particle request, result request and register write channels.
// ----------------------------------------------------------------------------
interface scts_item_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [30:0]        soft_req;
  logic [31:0]        particle_id;
  logic               deleted;
  logic               last;

  modport source (output valid, action, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  soft_req, particle_id, deleted, last, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                soft_req, particle_id, deleted, last, output ready);
endinterface

interface scts_result_if;
  logic        valid;
  logic        ready;
  logic [30:0] soonest_time;
  logic [1:0]  partner_kind;
  logic [31:0] partner_id;
  logic        near_hit;

  modport source (output valid, soonest_time, partner_kind, partner_id, near_hit,
                  input ready);
  modport sink (input valid, soonest_time, partner_kind, partner_id, near_hit,
                output ready);
endinterface

interface scts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/scts_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere collision time search shared arithmetic unit
// Multi-cycle 64x64 multiply, 128-bit integer square root and long division.
// ----------------------------------------------------------------------------
module scts_arith (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire scts_pkg::arith_req_t      req_i,
  output scts_pkg::arith_sts_t           sts_o,
  output logic [scts_pkg::WideW-1:0]     res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [6:0]                    cnt_q, cnt_d;
  scts_pkg::arith_op_e           op_q, op_d;
  logic [scts_pkg::WideW-1:0]    a_q, a_d;
  logic [scts_pkg::MulW-1:0]     b_q, b_d;
  logic [scts_pkg::WideW-1:0]    acc_q, acc_d;
  logic [scts_pkg::RemW-1:0]     rem_q, rem_d;
  logic [63:0]                   root_q, root_d;

  logic [31:0]                   a_sel, b_sel;
  logic [63:0]                   pp;
  logic [6:0]                    pp_sh;
  logic [scts_pkg::RemW-1:0]     sq_rem, sq_trial, dv_rem, dv_div;
  logic                          sq_ge, dv_ge;
  logic [6:0]                    cnt_last;

  always_comb begin
    a_sel    = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_sel    = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp       = 64'(a_sel) * 64'(b_sel);
    pp_sh    = {(2'({1'b0, cnt_q[1]}) + 2'({1'b0, cnt_q[0]})), 5'b0};
    sq_rem   = {rem_q[scts_pkg::RemW-3:0], a_q[scts_pkg::WideW-1 -: 2]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = sq_rem >= sq_trial;
    dv_rem   = {rem_q[scts_pkg::RemW-2:0], a_q[scts_pkg::QW-1]};
    dv_div   = {4'b0, b_q};
    dv_ge    = dv_rem >= dv_div;
  end

  always_comb begin
    unique case (op_q)
      scts_pkg::OP_MUL:  cnt_last = 7'd3;
      scts_pkg::OP_SQRT: cnt_last = 7'd63;
      scts_pkg::OP_DIV:  cnt_last = 7'(scts_pkg::QW - 1);
      default:           cnt_last = 7'd3;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        op_d   = req_i.op;
        a_d    = req_i.a;
        b_d    = req_i.b;
        acc_d  = '0;
        root_d = '0;
        if (req_i.op == scts_pkg::OP_DIV) begin
          rem_d = req_i.a[scts_pkg::QW +: scts_pkg::RemW];
        end else begin
          rem_d = '0;
        end
      end
    end else begin
      unique case (op_q)
        scts_pkg::OP_MUL: begin
          acc_d = acc_q + ({64'b0, pp} << pp_sh);
        end
        scts_pkg::OP_SQRT: begin
          a_d    = a_q << 2;
          rem_d  = sq_ge ? (sq_rem - sq_trial) : sq_rem;
          root_d = {root_q[62:0], sq_ge};
        end
        scts_pkg::OP_DIV: begin
          a_d    = a_q << 1;
          rem_d  = dv_ge ? (dv_rem - dv_div) : dv_rem;
          root_d = {root_q[62:0], dv_ge};
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == cnt_last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= scts_pkg::OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = (op_q == scts_pkg::OP_MUL) ? acc_q : {64'b0, root_q};

endmodule

`default_nettype wire

>>> src/sphere_collision_time_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere collision time search core
// Soonest wall or sphere collision of one home sphere over its neighbor list.
// ----------------------------------------------------------------------------
// load: the wall test takes one multiply and one 31-step division
// requests: one at a time; a new one is taken only in idle, once the last is
//   done; the shared multiply / sqrt / divide unit does every product, root and quotient
// reset: home sphere counts as deleted, best time none, registers at defaults

module sphere_collision_time_search_core (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  scts_item_if.sink         item_i,
  scts_result_if.source     result_o,
  scts_cfg_if.sink          cfg_i
);

  localparam logic [scts_pkg::WideW-1:0] S2Cap = scts_pkg::WideW'(1) << 62;

  // configuration
  logic        near_mode_q, wall_en_q;
  logic signed [31:0] wall_z_q;
  logic [30:0] sub_step_q;
  logic [15:0] step_fac_q;

  // current request
  logic               act_q, del_q, last_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [30:0]        soft_q;
  logic [scts_pkg::IdW-1:0] id_q;

  // home sphere
  logic signed [31:0] hpos_q [3];
  logic signed [31:0] hvel_q [3];
  logic [30:0]        hsoft_q;
  logic [scts_pkg::IdW-1:0] hid_q;
  logic               hdel_q;

  // search state
  scts_pkg::state_e   state_q, state_d;
  logic               go_q, go_d;
  logic [1:0]         axis_q, axis_d, term_q, term_d;
  logic signed [scts_pkg::AccW-1:0] r_q, r_d, vv_q, vv_d, xx_q, xx_d;
  logic [scts_pkg::SrW-1:0]   sr_q, sr_d;
  logic signed [scts_pkg::DrW-1:0] dr2_q, dr2_d;
  logic [scts_pkg::WideW-1:0] r2_q, r2_d, d_q, d_d;
  logic [scts_pkg::AccW-1:0]  num_q, num_d;
  logic [31:0]                best_time_q, best_time_d;
  scts_pkg::kind_e            best_kind_q, best_kind_d;
  logic [scts_pkg::IdW-1:0]   best_part_q, best_part_d;
  logic                       near_q, near_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [30:0] out_time_q, out_time_d;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [31:0] out_id_q, out_id_d;
  logic        out_near_q, out_near_d;

  scts_pkg::arith_req_t        arith_req;
  scts_pkg::arith_sts_t        arith_sts;
  logic [scts_pkg::WideW-1:0]  arith_res;

  logic item_accept;
  logic signed [scts_pkg::XW-1:0] dx_ax, dv_ax;
  logic [scts_pkg::XW-1:0]        dx_m, dv_m, vz_m;
  logic signed [scts_pkg::NW-1:0] wall_num;
  logic [scts_pkg::NW-1:0]        wall_m;
  logic                           wall_ok;
  logic [scts_pkg::WideW-1:0]     wall_n, lhs, sq_sh, d_sum, d_dif;
  logic [32:0]                    sr_col;
  logic [scts_pkg::AccW-1:0]      r_m, vv_u, prod;
  logic signed [scts_pkg::AccW-1:0] prod_s;
  logic                           prod_neg;
  logic [62:0]                    s2;
  logic signed [scts_pkg::DrW-1:0] dr2_n;
  logic [scts_pkg::DrW-1:0]       dr2_m;
  logic [63:0]                    root;
  logic [scts_pkg::QW-1:0]        quot;
  logic                           emit;

  assign item_accept  = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == scts_pkg::ST_IDLE);
  assign cfg_i.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_mode_q <= 1'b0;
      wall_en_q   <= 1'b0;
      wall_z_q    <= '0;
      sub_step_q  <= 31'd65536;
      step_fac_q  <= 16'd640;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (scts_pkg::cfg_reg_e'(cfg_i.index))
        scts_pkg::CFG_NEAR_MODE:   near_mode_q <= cfg_i.data[0];
        scts_pkg::CFG_WALL_ENABLE: wall_en_q   <= cfg_i.data[0];
        scts_pkg::CFG_WALL_Z:      wall_z_q    <= $signed(cfg_i.data);
        scts_pkg::CFG_SUB_STEP:    sub_step_q  <= cfg_i.data[30:0];
        scts_pkg::CFG_STEP_FAC:    step_fac_q  <= cfg_i.data[15:0];
        default: begin
        end
      endcase
    end
  end

  // request and home sphere capture
  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      act_q    <= item_i.action;
      del_q    <= item_i.deleted;
      last_q   <= item_i.last;
      pos_q[0] <= item_i.pos_x;
      pos_q[1] <= item_i.pos_y;
      pos_q[2] <= item_i.pos_z;
      vel_q[0] <= item_i.vel_x;
      vel_q[1] <= item_i.vel_y;
      vel_q[2] <= item_i.vel_z;
      soft_q   <= item_i.soft_req;
      id_q     <= item_i.particle_id[scts_pkg::IdW-1:0];
      if (!item_i.action) begin
        hpos_q[0] <= item_i.pos_x;
        hpos_q[1] <= item_i.pos_y;
        hpos_q[2] <= item_i.pos_z;
        hvel_q[0] <= item_i.vel_x;
        hvel_q[1] <= item_i.vel_y;
        hvel_q[2] <= item_i.vel_z;
        hsoft_q   <= item_i.soft_req;
        hid_q     <= item_i.particle_id[scts_pkg::IdW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdel_q <= 1'b1;
    end else if (item_accept && !item_i.action) begin
      hdel_q <= item_i.deleted;
    end
  end

  // datapath terms
  always_comb begin
    dx_ax    = scts_pkg::XW'(hpos_q[axis_q]) - scts_pkg::XW'(pos_q[axis_q]);
    dv_ax    = scts_pkg::XW'(hvel_q[axis_q]) - scts_pkg::XW'(vel_q[axis_q]);
    dx_m     = dx_ax[scts_pkg::XW-1] ? scts_pkg::XW'(-dx_ax) : scts_pkg::XW'(dx_ax);
    dv_m     = dv_ax[scts_pkg::XW-1] ? scts_pkg::XW'(-dv_ax) : scts_pkg::XW'(dv_ax);
    vz_m     = hvel_q[2][31] ? scts_pkg::XW'(-scts_pkg::XW'(hvel_q[2]))
                             : scts_pkg::XW'(hvel_q[2]);
    wall_num = scts_pkg::NW'(wall_z_q) - scts_pkg::NW'(hpos_q[2])
             - $signed({3'b000, hsoft_q, 1'b0});
    wall_m   = wall_num[scts_pkg::NW-1] ? scts_pkg::NW'(-wall_num)
                                        : scts_pkg::NW'(wall_num);
    wall_ok  = (hvel_q[2] != '0) && (wall_num != '0)
            && (wall_num[scts_pkg::NW-1] == hvel_q[2][31]);
    wall_n   = scts_pkg::WideW'(wall_m) << scts_pkg::FRAC_BITS;
    sr_col   = {(32'(hsoft_q) + 32'(soft_q)), 1'b0};
    r_m      = r_q[scts_pkg::AccW-1] ? scts_pkg::AccW'(-r_q) : scts_pkg::AccW'(r_q);
    vv_u     = scts_pkg::AccW'(vv_q);
    dr2_m    = dr2_q[scts_pkg::DrW-1] ? scts_pkg::DrW'(-dr2_q) : scts_pkg::DrW'(dr2_q);
    lhs      = scts_pkg::WideW'(num_q) << scts_pkg::FRAC_BITS;
    prod     = arith_res[scts_pkg::FRAC_BITS +: scts_pkg::AccW];
    prod_neg = (term_q == 2'd0) && (dx_ax[scts_pkg::XW-1] != dv_ax[scts_pkg::XW-1]);
    prod_s   = prod_neg ? -$signed(prod) : $signed(prod);
    sq_sh    = arith_res >> scts_pkg::FRAC_BITS;
    s2       = (sq_sh > S2Cap) ? S2Cap[62:0] : sq_sh[62:0];
    dr2_n    = scts_pkg::DrW'(xx_q) - $signed({1'b0, s2});
    d_sum    = r2_q + arith_res;
    d_dif    = r2_q - arith_res;
    root     = arith_res[63:0];
    quot     = arith_res[scts_pkg::QW-1:0];
    emit     = last_q && !hdel_q;
  end

  // shared unit operands
  always_comb begin
    arith_req.start = go_q;
    arith_req.op    = scts_pkg::OP_MUL;
    arith_req.a     = '0;
    arith_req.b     = '0;
    unique case (state_q)
      scts_pkg::ST_WALL_MUL: begin
        arith_req.a = scts_pkg::WideW'(sub_step_q);
        arith_req.b = scts_pkg::MulW'(vz_m);
      end
      scts_pkg::ST_WALL_DIV: begin
        arith_req.op = scts_pkg::OP_DIV;
        arith_req.a  = wall_n;
        arith_req.b  = scts_pkg::MulW'(vz_m);
      end
      scts_pkg::ST_DOT: begin
        arith_req.a = scts_pkg::WideW'((term_q == 2'd1) ? dv_m : dx_m);
        arith_req.b = scts_pkg::MulW'((term_q == 2'd2) ? dx_m : dv_m);
      end
      scts_pkg::ST_SR: begin
        arith_req.a = scts_pkg::WideW'(step_fac_q);
        arith_req.b = scts_pkg::MulW'(sr_col);
      end
      scts_pkg::ST_SQ: begin
        arith_req.a = scts_pkg::WideW'(sr_q);
        arith_req.b = scts_pkg::MulW'(sr_q);
      end
      scts_pkg::ST_R2: begin
        arith_req.a = scts_pkg::WideW'(r_m);
        arith_req.b = scts_pkg::MulW'(r_m);
      end
      scts_pkg::ST_PV: begin
        arith_req.a = scts_pkg::WideW'(dr2_m);
        arith_req.b = scts_pkg::MulW'(vv_u);
      end
      scts_pkg::ST_SQRT: begin
        arith_req.op = scts_pkg::OP_SQRT;
        arith_req.a  = d_q;
      end
      scts_pkg::ST_RHS: begin
        arith_req.a = scts_pkg::WideW'(sub_step_q);
        arith_req.b = scts_pkg::MulW'(vv_u);
      end
      scts_pkg::ST_DIV: begin
        arith_req.op = scts_pkg::OP_DIV;
        arith_req.a  = lhs;
        arith_req.b  = scts_pkg::MulW'(vv_u);
      end
      default: begin
        arith_req.op = scts_pkg::OP_MUL;
      end
    endcase
  end

  scts_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .sts_o  (arith_sts),
    .res_o  (arith_res)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    go_d        = 1'b0;
    axis_d      = axis_q;
    term_d      = term_q;
    r_d         = r_q;
    vv_d        = vv_q;
    xx_d        = xx_q;
    sr_d        = sr_q;
    dr2_d       = dr2_q;
    r2_d        = r2_q;
    d_d         = d_q;
    num_d       = num_q;
    best_time_d = best_time_q;
    best_kind_d = best_kind_q;
    best_part_d = best_part_q;
    near_d      = near_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_time_d  = out_time_q;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_near_d  = out_near_q;
    unique case (state_q)
      scts_pkg::ST_IDLE: begin
        if (item_accept) begin
          state_d = scts_pkg::ST_CHECK;
          if (!item_i.action) begin
            best_time_d = '1;
            best_kind_d = scts_pkg::KIND_NONE;
            best_part_d = '0;
            near_d      = 1'b0;
          end
        end
      end
      scts_pkg::ST_CHECK: begin
        state_d = scts_pkg::ST_FINISH;
        if (!act_q) begin
          if (!hdel_q && wall_en_q && wall_ok) begin
            state_d = scts_pkg::ST_WALL_MUL;
            go_d    = 1'b1;
          end
        end else if (!hdel_q && (id_q != hid_q) && !del_q
                     && !(near_mode_q && (best_kind_q != scts_pkg::KIND_NONE))) begin
          state_d = scts_pkg::ST_DOT;
          go_d    = 1'b1;
          axis_d  = '0;
          term_d  = '0;
          r_d     = '0;
          vv_d    = '0;
          xx_d    = '0;
        end
      end
      scts_pkg::ST_WALL_MUL: begin
        if (arith_sts.done) begin
          if ((wall_n >= scts_pkg::WideW'(vz_m)) && (wall_n < arith_res)) begin
            state_d = scts_pkg::ST_WALL_DIV;
            go_d    = 1'b1;
          end else begin
            state_d = scts_pkg::ST_FINISH;
          end
        end
      end
      scts_pkg::ST_WALL_DIV: begin
        if (arith_sts.done) begin
          best_time_d = {1'b0, quot};
          best_kind_d = scts_pkg::KIND_WALL;
          best_part_d = '0;
          state_d     = scts_pkg::ST_FINISH;
        end
      end
      scts_pkg::ST_DOT: begin
        if (arith_sts.done) begin
          case (term_q)
            2'd0:    r_d  = r_q + prod_s;
            2'd1:    vv_d = vv_q + prod_s;
            default: xx_d = xx_q + prod_s;
          endcase
          go_d = 1'b1;
          if (term_q == 2'd2) begin
            term_d = '0;
            axis_d = axis_q + 2'd1;
            if (axis_q == 2'd2) begin
              if (near_mode_q) begin
                state_d = scts_pkg::ST_SR;
              end else begin
                state_d = scts_pkg::ST_SQ;
                sr_d    = scts_pkg::SrW'(sr_col);
              end
            end
          end else begin
            term_d = term_q + 2'd1;
          end
        end
      end
      scts_pkg::ST_SR: begin
        if (arith_sts.done) begin
          sr_d    = arith_res[scts_pkg::StepFacShift +: scts_pkg::SrW];
          state_d = scts_pkg::ST_SQ;
          go_d    = 1'b1;
        end
      end
      scts_pkg::ST_SQ: begin
        if (arith_sts.done) begin
          dr2_d   = dr2_n;
          state_d = scts_pkg::ST_FINISH;
          if (near_mode_q && dr2_n[scts_pkg::DrW-1]) begin
            near_d = 1'b1;
          end else if ((vv_q != '0) && r_q[scts_pkg::AccW-1]) begin
            state_d = scts_pkg::ST_R2;
            go_d    = 1'b1;
          end
        end
      end
      scts_pkg::ST_R2: begin
        if (arith_sts.done) begin
          r2_d    = arith_res;
          state_d = scts_pkg::ST_PV;
          go_d    = 1'b1;
        end
      end
      scts_pkg::ST_PV: begin
        if (arith_sts.done) begin
          state_d = scts_pkg::ST_FINISH;
          if (dr2_q[scts_pkg::DrW-1] || (dr2_q == '0)) begin
            d_d = d_sum;
            if (d_sum != '0) begin
              state_d = scts_pkg::ST_SQRT;
              go_d    = 1'b1;
            end
          end else begin
            d_d = d_dif;
            if ((arith_res < r2_q) && (d_dif != '0)) begin
              state_d = scts_pkg::ST_SQRT;
              go_d    = 1'b1;
            end
          end
        end
      end
      scts_pkg::ST_SQRT: begin
        if (arith_sts.done) begin
          state_d = scts_pkg::ST_FINISH;
          num_d   = r_m - root[scts_pkg::AccW-1:0];
          if (64'(r_m) > root) begin
            state_d = scts_pkg::ST_RHS;
            go_d    = 1'b1;
          end
        end
      end
      scts_pkg::ST_RHS: begin
        if (arith_sts.done) begin
          state_d = scts_pkg::ST_FINISH;
          if (lhs < arith_res) begin
            state_d = scts_pkg::ST_DIV;
            go_d    = 1'b1;
          end
        end
      end
      scts_pkg::ST_DIV: begin
        if (arith_sts.done) begin
          state_d = scts_pkg::ST_FINISH;
          if (quot != '0) begin
            if (near_mode_q) begin
              near_d = 1'b1;
            end else if ({1'b0, quot} < best_time_q) begin
              best_time_d = {1'b0, quot};
              best_kind_d = scts_pkg::KIND_PART;
              best_part_d = id_q;
            end
          end
        end
      end
      scts_pkg::ST_FINISH: begin
        if (!emit) begin
          state_d = scts_pkg::ST_IDLE;
        end else if (!out_valid_q || result_o.ready) begin
          state_d     = scts_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          out_time_d  = best_time_q[31] ? '1 : best_time_q[30:0];
          out_kind_d  = best_kind_q;
          out_id_d    = (best_kind_q == scts_pkg::KIND_PART) ? 32'(best_part_q) : '0;
          out_near_d  = near_q;
        end
      end
      default: begin
        state_d = scts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scts_pkg::ST_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      best_time_q <= '1;
      best_kind_q <= scts_pkg::KIND_NONE;
      best_part_q <= '0;
      near_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
      best_time_q <= best_time_d;
      best_kind_q <= best_kind_d;
      best_part_q <= best_part_d;
      near_q      <= near_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q     <= axis_d;
    term_q     <= term_d;
    r_q        <= r_d;
    vv_q       <= vv_d;
    xx_q       <= xx_d;
    sr_q       <= sr_d;
    dr2_q      <= dr2_d;
    r2_q       <= r2_d;
    d_q        <= d_d;
    num_q      <= num_d;
    out_time_q <= out_time_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_near_q <= out_near_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.soonest_time = out_time_q;
  assign result_o.partner_kind = out_kind_q;
  assign result_o.partner_id   = out_id_q;
  assign result_o.near_hit     = out_near_q;

  // shared unit is only started when free
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_req.start |-> !arith_sts.busy)
    else $error("shared unit started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_sts.done |=> !arith_sts.done)
    else $error("shared unit done held");

  a_none_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.partner_kind == 2'(scts_pkg::KIND_NONE)))
      |-> (result_o.soonest_time == '1))
    else $error("result without partner carries a time");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == scts_pkg::ST_IDLE) && !item_accept) |=> (state_q == scts_pkg::ST_IDLE))
    else $error("sequencer left idle without a request");

endmodule

`default_nettype wire

>>> sim/tb_sphere_collision_time_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere collision time search core testbench
// Drives home sphere and neighbor requests through several register settings,
// predicts each result from its own fixed point model and checks it in order.
// ----------------------------------------------------------------------------
module tb_sphere_collision_time_search_core;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 300;
  localparam int LongHold = 1500;

  typedef struct {
    bit               action;
    logic signed [31:0] px, py, pz, vx, vy, vz;
    bit [30:0]        soft_len;
    bit [31:0]        id;
    bit               del;
    bit               last;
  } sphere_req_t;

  typedef struct {
    bit [30:0] t;
    bit [1:0]  kind;
    bit [31:0] pid;
    bit        near;
  } hit_t;

  class collision_scoreboard;
    bit               near_mode, wall_enable;
    longint           wall_z;
    longint unsigned  sub_step, step_fac;
    longint           hpos[3], hvel[3];
    longint unsigned  hsoft, hid, best_time, best_partner;
    bit               hdel, near_flag;
    bit [1:0]         best_kind;
    hit_t             expected_hits[$];
    int               errors;

    function void clear();
      near_mode = 0; wall_enable = 0; wall_z = 0; sub_step = 65536; step_fac = 640;
      for (int i = 0; i < 3; i++) begin
        hpos[i] = 0;
        hvel[i] = 0;
      end
      hsoft = 0; hid = 0; hdel = 1;
      best_time = 64'hFFFF_FFFF; best_kind = scts_pkg::KIND_NONE; best_partner = 0;
      near_flag = 0;
      errors = 0;
    endfunction

    function void write_reg(scts_pkg::cfg_reg_e idx, bit [31:0] data);
      case (idx)
        scts_pkg::CFG_NEAR_MODE: near_mode = data[0];
        scts_pkg::CFG_WALL_ENABLE: wall_enable = data[0];
        scts_pkg::CFG_WALL_Z: wall_z = longint'($signed(data));
        scts_pkg::CFG_SUB_STEP: sub_step = data[30:0];
        scts_pkg::CFG_STEP_FAC: step_fac = data[15:0];
        default: ;
      endcase
    endfunction

    function longint scaled_product(longint a, longint b);
      logic [127:0] p;
      longint unsigned ma, mb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = ({64'b0, ma} * {64'b0, mb}) >> scts_pkg::FRAC_BITS;
      return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function bit closing_root(longint r, longint v, longint dr2, output longint unsigned t);
      logic [127:0] r2, pv, d, lhs, rhs, tt, q;
      longint unsigned s, mr, cand, mdr;
      t = 0;
      if (v <= 0) return 0;
      mr = (r < 0) ? -r : r;
      mdr = (dr2 < 0) ? -dr2 : dr2;
      r2 = {64'b0, mr} * {64'b0, mr};
      pv = {64'b0, mdr} * {64'b0, v};
      if (dr2 <= 0) d = r2 + pv;
      else begin
        if (!(pv < r2)) return 0;
        d = r2 - pv;
      end
      if (d == 0) return 0;
      s = 0;
      for (int b = 62; b >= 0; b--) begin
        cand = s | (64'd1 << b);
        tt = {64'b0, cand} * {64'b0, cand};
        if (!(d < tt)) s = cand;
      end
      if (r >= 0) return 0;
      if (mr <= s) return 0;
      lhs = {64'b0, mr - s} << scts_pkg::FRAC_BITS;
      rhs = {64'b0, sub_step} * {64'b0, v};
      if (!(lhs < rhs)) return 0;
      q = lhs / {64'b0, v};
      if (q == 0) return 0;
      t = q[63:0];
      return 1;
    endfunction

    function void wall_time();
      longint num, vz;
      longint unsigned q, mn, mv;
      num = wall_z - hpos[2] - 2 * longint'(hsoft);
      vz = hvel[2];
      if (vz == 0 || num == 0 || ((num < 0) != (vz < 0))) return;
      mn = (num < 0) ? -num : num;
      mv = (vz < 0) ? -vz : vz;
      q = (mn << scts_pkg::FRAC_BITS) / mv;
      if (q > 0 && q < sub_step) begin
        best_time = q; best_kind = scts_pkg::KIND_WALL; best_partner = 0;
      end
    endfunction

    function void neighbor_time(sphere_req_t it);
      longint dx[3], dv[3], r, vv, xx, dr2, nb_p[3], nb_v[3];
      longint unsigned sr, s2, t;
      logic [127:0] sq;
      nb_p[0] = it.px; nb_p[1] = it.py; nb_p[2] = it.pz;
      nb_v[0] = it.vx; nb_v[1] = it.vy; nb_v[2] = it.vz;
      r = 0; vv = 0; xx = 0;
      for (int i = 0; i < 3; i++) begin
        dx[i] = hpos[i] - nb_p[i];
        dv[i] = hvel[i] - nb_v[i];
        r += scaled_product(dx[i], dv[i]);
        vv += scaled_product(dv[i], dv[i]);
        xx += scaled_product(dx[i], dx[i]);
      end
      if (near_mode)
        sr = (step_fac * (2 * (hsoft + it.soft_len))) >> scts_pkg::StepFacShift;
      else sr = 2 * hsoft + 2 * it.soft_len;
      sq = ({64'b0, sr} * {64'b0, sr}) >> scts_pkg::FRAC_BITS;
      s2 = (sq > (128'd1 << 62)) ? (64'd1 << 62) : sq[63:0];
      dr2 = xx - longint'(s2);
      if (near_mode) begin
        if (best_kind != scts_pkg::KIND_NONE) return;
        if (dr2 < 0 || closing_root(r, vv, dr2, t)) near_flag = 1;
      end else if (closing_root(r, vv, dr2, t) && t < best_time) begin
        best_time = t; best_kind = scts_pkg::KIND_PART; best_partner = it.id;
      end
    endfunction

    function void note_request(sphere_req_t it);
      hit_t h;
      if (!it.action) begin
        hpos[0] = it.px; hpos[1] = it.py; hpos[2] = it.pz;
        hvel[0] = it.vx; hvel[1] = it.vy; hvel[2] = it.vz;
        hsoft = it.soft_len; hid = it.id; hdel = it.del;
        best_time = 64'hFFFF_FFFF; best_kind = scts_pkg::KIND_NONE; best_partner = 0;
        near_flag = 0;
        if (!hdel && wall_enable) wall_time();
      end else if (!hdel && it.id != hid && !it.del) begin
        neighbor_time(it);
      end
      if (!it.last || hdel) return;
      h.t = (best_time > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : best_time[30:0];
      h.kind = best_kind;
      h.pid = (best_kind == scts_pkg::KIND_PART) ? best_partner[31:0] : 32'd0;
      h.near = near_flag;
      expected_hits.push_back(h);
    endfunction

    function void check_result(hit_t got);
      hit_t e;
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected result time %h kind %0d id %h", $time, got.t, got.kind,
                 got.pid);
        errors++;
        return;
      end
      e = expected_hits.pop_front();
      if (got.t !== e.t) begin
        $display("%0t soonest_time exp %h got %h", $time, e.t, got.t);
        errors++;
      end
      if (got.kind !== e.kind) begin
        $display("%0t partner_kind exp %0d got %0d", $time, e.kind, got.kind);
        errors++;
      end
      if (got.pid !== e.pid) begin
        $display("%0t partner_id exp %h got %h", $time, e.pid, got.pid);
        errors++;
      end
      if (got.near !== e.near) begin
        $display("%0t near_hit exp %0d got %0d", $time, e.near, got.near);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  scts_item_if item_if();
  scts_result_if result_if();
  scts_cfg_if cfg_if();

  sphere_collision_time_search_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (result_if.source),
    .cfg_i    (cfg_if.sink)
  );

  always #5 clk_i = ~clk_i;

  collision_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  initial begin
    item_if.valid = 0; item_if.action = 0; item_if.pos_x = 0; item_if.pos_y = 0;
    item_if.pos_z = 0; item_if.vel_x = 0; item_if.vel_y = 0; item_if.vel_z = 0;
    item_if.soft_req = 0; item_if.particle_id = 0; item_if.deleted = 0; item_if.last = 0;
    result_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = scts_pkg::CFG_NEAR_MODE; cfg_if.data = 0;
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side, random stalls and one long hold-off
  initial begin
    hit_t got;
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    result_if.ready <= 1;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        got.t = result_if.soonest_time; got.kind = result_if.partner_kind;
        got.pid = result_if.partner_id; got.near = result_if.near_hit;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req = 0;
        result_if.ready <= 0;
        repeat (LongHold) @(posedge clk_i);
        result_if.ready <= 1;
      end else if (result_if.valid && result_if.ready && !no_idle) begin
        n = $urandom_range(0, 4);
        if (n > 0) begin
          result_if.ready <= 0;
          repeat (n) @(posedge clk_i);
          result_if.ready <= 1;
        end
      end
    end
  end

  task automatic write_reg(scts_pkg::cfg_reg_e idx, bit [31:0] data);
    cfg_if.valid <= 1; cfg_if.index <= idx; cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    cfg_if.valid <= 0;
  endtask

  task automatic send_request(sphere_req_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1; item_if.action <= it.action;
    item_if.pos_x <= it.px; item_if.pos_y <= it.py; item_if.pos_z <= it.pz;
    item_if.vel_x <= it.vx; item_if.vel_y <= it.vy; item_if.vel_z <= it.vz;
    item_if.soft_req <= it.soft_len; item_if.particle_id <= it.id;
    item_if.deleted <= it.del; item_if.last <= it.last;
    do @(posedge clk_i); while (!item_if.ready);
    sb.note_request(it);
  endtask

  task automatic settle();
    item_if.valid <= 0;
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] near_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic sphere_req_t random_req();
    sphere_req_t it;
    it.action = $urandom_range(0, 1);
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
    it.soft_len = $urandom; it.id = $urandom;
    it.del = $urandom_range(0, 1); it.last = $urandom_range(0, 1);
    return it;
  endfunction

  task automatic run_group(ref int sent);
    sphere_req_t home, nb;
    int k;
    if ($urandom_range(0, 9) == 0) begin
      send_request(random_req());
      sent++;
      return;
    end
    home.action = 0;
    home.px = near_val(1 << 20); home.py = near_val(1 << 20); home.pz = near_val(1 << 20);
    home.vx = near_val(1 << 17); home.vy = near_val(1 << 17);
    home.vz = ($urandom_range(0, 7) == 0) ? 0 : near_val(1 << 18);
    home.soft_len = $urandom_range(1 << 10, 1 << 15);
    home.id = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom;
    home.del = ($urandom_range(0, 19) == 0);
    k = $urandom_range(0, 5);
    home.last = (k == 0);
    send_request(home);
    sent++;
    for (int i = 0; i < k; i++) begin
      nb.action = 1;
      nb.px = home.px + near_val(1 << 18); nb.py = home.py + near_val(1 << 18);
      nb.pz = home.pz + near_val(1 << 18);
      nb.vx = home.vx + (home.px > nb.px ? 1 : -1) * $signed($urandom_range(0, 1 << 18));
      nb.vy = home.vy + (home.py > nb.py ? 1 : -1) * $signed($urandom_range(0, 1 << 18));
      nb.vz = home.vz + (home.pz > nb.pz ? 1 : -1) * $signed($urandom_range(0, 1 << 18));
      nb.soft_len = $urandom_range(1 << 10, 1 << 16);
      nb.id = ($urandom_range(0, 9) == 0) ? home.id : $urandom;
      nb.del = ($urandom_range(0, 14) == 0);
      nb.last = (i == k - 1);
      send_request(nb);
      sent++;
    end
  endtask

  task automatic directed();
    sphere_req_t it;
    // neighbor, in the first pass before any load, so the home counts as deleted
    it = '{1, 0, 0, 0, 0, 0, 0, 1000, 5, 0, 1};
    send_request(it);
    // home at the extremes, last on the load
    it = '{0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
           32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1};
    send_request(it);
    // home, then a self neighbor, a deleted neighbor and a head-on neighbor
    it = '{0, 0, 0, 0, 32'sh0001_0000, 0, 0, 31'h1000, 1, 0, 0};
    send_request(it);
    it = '{1, 32'sh0000_8000, 0, 0, 32'sh8000_0000, 0, 0, 31'h1000, 1, 0, 0};
    send_request(it);
    it = '{1, 32'sh0000_8000, 0, 0, 32'shFFFF_0000, 0, 0, 31'h1000, 9, 1, 0};
    send_request(it);
    it = '{1, 32'sh0000_8000, 0, 0, 32'shFFFF_0000, 0, 0, 31'h1000, 7, 0, 0};
    send_request(it);
    // no relative motion, then overlap at rest
    it = '{1, 32'sh0004_0000, 0, 0, 32'sh0001_0000, 0, 0, 31'h1000, 8, 0, 0};
    send_request(it);
    it = '{1, 32'sh0000_0100, 0, 0, 32'sh0001_0000, 0, 0, 31'h1000, 6, 0, 1};
    send_request(it);
    // deleted home, neighbors ignored and no result
    it = '{0, 0, 0, 0, 32'sh0001_0000, 0, 0, 31'h1000, 2, 1, 0};
    send_request(it);
    it = '{1, 32'sh0000_8000, 0, 0, 32'shFFFF_0000, 0, 0, 31'h1000, 3, 0, 1};
    send_request(it);
    // zero z velocity and a wall-bound load
    it = '{0, 0, 0, 0, 0, 0, 0, 31'h100, 4, 0, 1};
    send_request(it);
    it = '{0, 0, 0, 0, 0, 0, 32'sh0001_0000, 31'h100, 4, 0, 0};
    send_request(it);
    it = '{1, 0, 0, 32'sh0000_2000, 0, 0, 32'shFFFF_0000, 31'h100, 11, 0, 1};
    send_request(it);
  endtask

  initial begin
    int sent;
    sb.clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(scts_pkg::CFG_WALL_Z, 32'h0000_4000);
        end
        1: begin
          write_reg(scts_pkg::CFG_WALL_ENABLE, 1);
          write_reg(scts_pkg::CFG_SUB_STEP, 31'h7FFF_FFFF);
        end
        2: begin
          write_reg(scts_pkg::CFG_NEAR_MODE, 1); write_reg(scts_pkg::CFG_STEP_FAC, 16'hFFFF);
        end
        3: begin
          write_reg(scts_pkg::CFG_STEP_FAC, 0); write_reg(scts_pkg::CFG_WALL_Z, 32'h8000_0000);
        end
        4: begin
          write_reg(scts_pkg::CFG_NEAR_MODE, 0); write_reg(scts_pkg::CFG_SUB_STEP, 0);
          write_reg(scts_pkg::CFG_WALL_Z, 32'h7FFF_FFFF);
        end
        5: begin
          write_reg(scts_pkg::CFG_SUB_STEP, 31'h0004_0000);
          write_reg(scts_pkg::CFG_WALL_Z, 32'hFFFE_0000);
          write_reg(scts_pkg::CFG_STEP_FAC, 16'd640);
        end
        default: begin
          write_reg(scts_pkg::CFG_NEAR_MODE, 1); write_reg(scts_pkg::CFG_WALL_ENABLE, 0);
        end
      endcase
      if (ph < 2) directed();
      no_idle = (ph == 3);
      if (ph == 1) hold_req = 1;
      while (sent < (ph + 1) * 280) run_group(sent);
      settle();
    end
    if (sb.errors == 0 && sb.expected_hits.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

>>> files.f
src/scts_pkg.sv
src/scts_if.sv
src/scts_arith.sv
src/sphere_collision_time_search_core.sv
sim/tb_sphere_collision_time_search_core.sv
